[src/assert_macros.svh]
// Assertion macros used by the queue sequencer (tsq_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/tsq_pkg.sv]
// Package with constants, codes and types of the two-stack queue.
package tsq_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int TOT_W       = CNT_W + 1;
  localparam int IDX_W       = 5;
  localparam int CMP_W       = (IDX_W > TOT_W) ? IDX_W : TOT_W;
  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 6;
  localparam int CAP_W       = 5;
  localparam int CAP_RESET   = 16;

  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_XFER_RD,
    S_XFER_WR,
    S_MEM_RD
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

[src/tsq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tsq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/tsq_ctrl.sv]
// Sequencer for the two-stack queue: counts, stack moves and result register.
`include "assert_macros.svh"

module tsq_ctrl
  import tsq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [CNT_W-1:0]  cap,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [DATA_W-1:0] in_value,
  input  logic [IDX_W-1:0]  in_index,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [DATA_W-1:0] res_data,
  output logic [1:0]        res_status,
  output logic [COUNT_W-1:0] res_count,
  output logic              res_full,
  output ram_req_t          in_req,
  input  logic [DATA_W-1:0] in_rdata,
  output ram_req_t          out_req,
  input  logic [DATA_W-1:0] out_rdata
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  in_count, in_count_next;
  logic [CNT_W-1:0]  out_count, out_count_next;
  logic              op_push, op_push_next;
  logic [DATA_W-1:0] val_hold, val_hold_next;
  logic              src_out, src_out_next;

  logic              accept;
  logic              in_at_cap;
  logic              full_now;
  logic [CMP_W-1:0]  total;
  logic              idx_ok;
  logic              idx_in_out;
  logic              load;
  logic [DATA_W-1:0] ld_data;
  logic [1:0]        ld_status;

  assign accept     = in_valid && in_ready;
  assign in_ready   = (state == S_IDLE) && (!res_valid || res_ready);
  assign in_at_cap  = in_count >= cap;
  assign full_now   = in_at_cap && (out_count != '0);
  assign total      = CMP_W'(in_count) + CMP_W'(out_count);
  assign idx_ok     = CMP_W'(in_index) < total;
  assign idx_in_out = CMP_W'(in_index) < CMP_W'(out_count);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_PUSH: begin
              if (!full_now && in_at_cap) state_next = S_XFER_RD;
            end
            KIND_POP: begin
              if (out_count != '0) state_next = S_MEM_RD;
              else if (in_count != '0) state_next = S_XFER_RD;
            end
            KIND_READ: begin
              if (idx_ok) state_next = S_MEM_RD;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_XFER_RD: state_next = S_XFER_WR;
      S_XFER_WR: begin
        if (in_count == CNT_W'(1)) state_next = S_IDLE;
        else state_next = S_XFER_RD;
      end
      S_MEM_RD:  state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_req         = '0;
    out_req        = '0;
    in_count_next  = in_count;
    out_count_next = out_count;
    op_push_next   = op_push;
    val_hold_next  = val_hold;
    src_out_next   = src_out;
    load           = 1'b0;
    ld_data        = '0;
    ld_status      = STAT_OK;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_PUSH: begin
              if (full_now) begin
                load      = 1'b1;
                ld_status = STAT_FULL;
              end else if (in_at_cap) begin
                op_push_next  = 1'b1;
                val_hold_next = in_value;
              end else begin
                in_req.we     = 1'b1;
                in_req.waddr  = in_count[ADDR_W-1:0];
                in_req.wdata  = in_value;
                in_count_next = CNT_W'(in_count + 1'b1);
                load          = 1'b1;
              end
            end
            KIND_POP: begin
              if (out_count != '0) begin
                out_req.raddr  = ADDR_W'(out_count - 1'b1);
                out_count_next = CNT_W'(out_count - 1'b1);
                src_out_next   = 1'b1;
              end else if (in_count == '0) begin
                load      = 1'b1;
                ld_status = STAT_EMPTY;
              end else begin
                op_push_next = 1'b0;
              end
            end
            KIND_READ: begin
              if (!idx_ok) begin
                load      = 1'b1;
                ld_status = STAT_RANGE;
              end else if (idx_in_out) begin
                out_req.raddr = ADDR_W'(CMP_W'(out_count) - CMP_W'(1) - CMP_W'(in_index));
                src_out_next  = 1'b1;
              end else begin
                in_req.raddr = ADDR_W'(CMP_W'(in_index) - CMP_W'(out_count));
                src_out_next = 1'b0;
              end
            end
            default: load = 1'b1;
          endcase
        end
      end
      S_XFER_RD: begin
        in_req.raddr = ADDR_W'(in_count - 1'b1);
      end
      S_XFER_WR: begin
        if (in_count == CNT_W'(1) && !op_push) begin
          ld_data       = in_rdata;
          in_count_next = '0;
          load          = 1'b1;
        end else begin
          out_req.we     = 1'b1;
          out_req.waddr  = out_count[ADDR_W-1:0];
          out_req.wdata  = in_rdata;
          out_count_next = CNT_W'(out_count + 1'b1);
          in_count_next  = CNT_W'(in_count - 1'b1);
          if (in_count == CNT_W'(1)) begin
            in_req.we     = 1'b1;
            in_req.waddr  = '0;
            in_req.wdata  = val_hold;
            in_count_next = CNT_W'(1);
            load          = 1'b1;
          end
        end
      end
      S_MEM_RD: begin
        load    = 1'b1;
        ld_data = src_out ? out_rdata : in_rdata;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_count  <= '0;
      out_count <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_count  <= in_count_next;
      out_count <= out_count_next;
      if (load) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    op_push  <= op_push_next;
    val_hold <= val_hold_next;
    src_out  <= src_out_next;
    if (load) begin
      res_data   <= ld_data;
      res_status <= ld_status;
      res_count  <= COUNT_W'(CMP_W'(in_count_next) + CMP_W'(out_count_next));
      res_full   <= (in_count_next >= cap) && (out_count_next != '0);
    end
  end

  `ASSERT_ALWAYS(a_count_bound, (in_count <= CNT_W'(STACK_DEPTH)) && (out_count <= CNT_W'(STACK_DEPTH)), "stack count beyond depth")
  `ASSERT_ALWAYS(a_busy_no_result, (state != S_IDLE) |-> !res_valid, "result pending while busy")
  `ASSERT_NEXT(a_xfer_pair, state == S_XFER_RD, state == S_XFER_WR, "move read not followed by write")
  `ASSERT_ALWAYS(a_xfer_room, (state == S_XFER_WR) |-> (out_count < CNT_W'(STACK_DEPTH)), "move overflows output stack")

endmodule

[src/two_stack_queue_unit.sv]
// Two-stack queue: top level with capacity register, stack memories and sequencer.
//
// A FIFO of 32-bit values held in an input stack and an output stack, each in its own
// RAM with registered read data. One result comes back for every transfer taken. A
// push, a rejected push, a pop of an empty queue, an out-of-range read and the unused
// kind load their result straight from the idle state; a pop or an indexed read first
// passes through S_MEM_RD to read a RAM. When a push meets an input stack at capacity
// with an empty output stack, or a pop meets an empty output stack, the input stack is
// first moved over element by element (a read of the input-stack RAM, then a write of
// the output-stack RAM); on such a pop the last element read becomes the result. One
// item is in work at a time; a waiting result holds off the input, and the next item is
// taken at the earliest in the cycle in which the last result is taken. The capacity
// register acts as 1 when written as zero and as the stack depth when written larger;
// write it only while the block is idle. There is no clearing pass after reset.
module two_stack_queue_unit
  import tsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [CAP_W-1:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // push_value[31:0], index[36:32], zero[39:37]
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // data[31:0], count[37:32], is_full[38], zero[39]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  logic [CAP_W-1:0]   cap_reg;
  logic [CNT_W-1:0]   cap_eff;
  ram_req_t           in_req, out_req;
  logic [DATA_W-1:0]  in_rdata, out_rdata;
  logic [DATA_W-1:0]  res_data;
  logic [1:0]         res_status;
  logic [COUNT_W-1:0] res_count;
  logic               res_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= CAP_W'(CAP_RESET);
    end else if (cfg_valid && cfg_ready) begin
      cap_reg <= cfg_data;
    end
  end

  always_comb begin
    if (cap_reg == '0) cap_eff = CNT_W'(1);
    else if (32'(cap_reg) > STACK_DEPTH) cap_eff = CNT_W'(STACK_DEPTH);
    else cap_eff = CNT_W'(cap_reg);
  end

  tsq_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH), .AW(ADDR_W)) u_in_ram (
    .clk   (clk),
    .we    (in_req.we),
    .waddr (in_req.waddr),
    .wdata (in_req.wdata),
    .raddr (in_req.raddr),
    .rdata (in_rdata)
  );

  tsq_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH), .AW(ADDR_W)) u_out_ram (
    .clk   (clk),
    .we    (out_req.we),
    .waddr (out_req.waddr),
    .wdata (out_req.wdata),
    .raddr (out_req.raddr),
    .rdata (out_rdata)
  );

  tsq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cap        (cap_eff),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_kind    (s_axis_tuser),
    .in_value   (s_axis_tdata[31:0]),
    .in_index   (s_axis_tdata[36:32]),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res_data   (res_data),
    .res_status (res_status),
    .res_count  (res_count),
    .res_full   (res_full),
    .in_req     (in_req),
    .in_rdata   (in_rdata),
    .out_req    (out_req),
    .out_rdata  (out_rdata)
  );

  assign m_axis_tdata = {1'b0, res_full, res_count, res_data};
  assign m_axis_tuser = res_status;

endmodule

[test/tb_top.sv]
// Testbench for the two-stack queue: directed and random stream traffic against a model.
module tb_top;
  import tsq_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int WATCH_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;
  localparam int RANDOM_OPS = 126;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [4:0]  index;
  } queue_op_t;

  typedef struct packed {
    logic [31:0] data;
    logic [1:0]  status;
    logic [5:0]  count;
    logic        is_full;
  } queue_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  two_stack_queue_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  queue_op_t    pending_ops[$];
  queue_reply_t expected_replies[$];
  queue_op_t    bus_op;

  logic [31:0] in_stk [STACK_DEPTH];
  logic [31:0] out_stk [STACK_DEPTH];
  int unsigned in_n = 0;
  int unsigned out_n = 0;
  logic [4:0]  cap_reg = CAP_W'(CAP_RESET);

  int ops_issued = 0;
  int replies_seen = 0;
  int n_errors = 0;
  int n_kind [4] = '{0, 0, 0, 0};
  int n_rejected = 0;
  int n_empty_pops = 0;
  int n_out_of_range = 0;
  int n_full_replies = 0;
  int n_cap_writes = 0;
  int peak_fill = 0;

  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  bit hold_started = 1'b0;
  logic [1:0] tx_gap = '0;
  logic [1:0] rx_gap = '0;
  logic [6:0] hold_left = '0;
  int quiet_cycles = 0;

  function automatic int unsigned cap_eff();
    if (cap_reg == 0) return 1;
    if (cap_reg > STACK_DEPTH) return STACK_DEPTH;
    return cap_reg;
  endfunction

  function automatic bit queue_at_limit();
    return in_n >= cap_eff() && out_n > 0;
  endfunction

  function automatic void move_in_to_out();
    while (in_n > 0 && out_n < STACK_DEPTH) begin
      in_n--;
      out_stk[out_n] = in_stk[in_n];
      out_n++;
    end
  endfunction

  function automatic void apply_queue_op(input queue_op_t op);
    queue_reply_t r;
    int unsigned total;
    r = '0;
    n_kind[op.kind]++;
    case (op.kind)
      KIND_PUSH: begin
        if (queue_at_limit()) begin
          r.status = STAT_FULL;
          n_rejected++;
        end else begin
          if (in_n >= cap_eff()) move_in_to_out();
          if (in_n < STACK_DEPTH) begin
            in_stk[in_n] = op.value;
            in_n++;
          end
        end
      end
      KIND_POP: begin
        if (out_n == 0) move_in_to_out();
        if (out_n == 0) begin
          r.status = STAT_EMPTY;
          n_empty_pops++;
        end else begin
          out_n--;
          r.data = out_stk[out_n];
        end
      end
      KIND_READ: begin
        total = in_n + out_n;
        if (op.index >= total) begin
          r.status = STAT_RANGE;
          n_out_of_range++;
        end else if (op.index < out_n) begin
          r.data = out_stk[out_n - 1 - op.index];
        end else begin
          r.data = in_stk[op.index - out_n];
        end
      end
      default: ;
    endcase
    r.count = 6'(in_n + out_n);
    r.is_full = queue_at_limit();
    if (r.is_full) n_full_replies++;
    if (in_n + out_n > peak_fill) peak_fill = in_n + out_n;
    expected_replies.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("tb_top: mismatch in %s at reply %0d: got %0h, expected %0h",
             what, replies_seen, got, want);
    n_errors++;
  endtask

  task automatic check_reply(input logic [39:0] tdata, input logic [1:0] tuser);
    queue_reply_t want;
    if (expected_replies.size() == 0) begin
      report_mismatch("reply with none expected", tdata[31:0], '0);
      return;
    end
    want = expected_replies.pop_front();
    if (tdata[31:0] !== want.data) report_mismatch("data", tdata[31:0], want.data);
    if (tuser !== want.status)
      report_mismatch("status", 32'(tuser), 32'(want.status));
    if (tdata[37:32] !== want.count)
      report_mismatch("count", 32'(tdata[37:32]), 32'(want.count));
    if (tdata[38] !== want.is_full)
      report_mismatch("is_full", 32'(tdata[38]), 32'(want.is_full));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      tx_gap <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_queue_op(bus_op);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 2'd1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0 && !no_idle && $urandom_range(0, 9) == 0) begin
          tx_gap <= 2'($urandom_range(0, 2));
          s_axis_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          bus_op = pending_ops.pop_front();
          s_axis_tdata <= {3'b000, bus_op.index, bus_op.value};
          s_axis_tuser <= bus_op.kind;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_gap <= '0;
      hold_left <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_reply(m_axis_tdata, m_axis_tuser);
        replies_seen++;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 7'd1;
        m_axis_tready <= 1'b0;
      end else if (hold_req && !hold_started) begin
        hold_started = 1'b1;
        hold_left <= 7'(HOLD_CYCLES);
        m_axis_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap <= rx_gap - 2'd1;
        m_axis_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        rx_gap <= 2'($urandom_range(0, 2));
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCH_LIMIT) begin
        $display("tb_top: stalled for %0d cycles with %0d replies outstanding",
                 quiet_cycles, ops_issued - replies_seen);
        $display("tb_top: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic add_op(input logic [1:0] kind, input logic [31:0] value,
                        input logic [4:0] index);
    queue_op_t op;
    op.kind = kind;
    op.value = value;
    op.index = index;
    pending_ops.push_back(op);
    ops_issued++;
  endtask

  task automatic add_random_ops(input int n);
    int run_left;
    int push_bias;
    int idx_top;
    logic [1:0]  kind;
    logic [31:0] value;
    logic [4:0]  index;
    run_left = 0;
    push_bias = 50;
    idx_top = 2 * int'(cap_eff());
    if (idx_top > 31) idx_top = 31;
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(8, 40);
        push_bias = $urandom_range(15, 85);
      end
      run_left--;
      case ($urandom_range(0, 99)) inside
        [0:3]:   kind = KIND_NONE;
        [4:21]:  kind = KIND_READ;
        default: kind = ($urandom_range(0, 99) < push_bias) ? KIND_PUSH : KIND_POP;
      endcase
      case ($urandom_range(0, 9))
        0:       value = 32'h7FFF_FFFF;
        1:       value = 32'h8000_0000;
        2:       value = 32'h0000_0000;
        3:       value = 32'hFFFF_FFFF;
        default: value = $urandom;
      endcase
      index = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                          : 5'($urandom_range(0, idx_top));
      add_op(kind, value, index);
    end
  endtask

  task automatic wait_drain();
    do @(posedge clk); while (replies_seen < ops_issued);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] cap);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(posedge clk); while (!cfg_ready);
    cap_reg = cap;
    n_cap_writes++;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [4:0] cap_plan [0:6];
    cap_plan = '{5'd31, 5'd3, 5'd0, 5'd1, 5'd16, 5'd20, 5'd9};
    cap_plan[6] = 5'($urandom_range(2, 15));
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    add_op(KIND_POP, 32'h0, 5'd0);
    add_op(KIND_READ, 32'h0, 5'd0);
    add_op(KIND_NONE, 32'hFFFF_FFFF, 5'd31);
    add_op(KIND_PUSH, 32'h7FFF_FFFF, 5'd0);
    add_op(KIND_PUSH, 32'h8000_0000, 5'd0);
    add_op(KIND_PUSH, 32'h0000_0000, 5'd0);
    add_op(KIND_PUSH, 32'hFFFF_FFFF, 5'd0);
    add_op(KIND_READ, 32'h0, 5'd0);
    add_op(KIND_READ, 32'h0, 5'd3);
    add_op(KIND_READ, 32'h0, 5'd4);
    add_op(KIND_READ, 32'h0, 5'd31);
    add_op(KIND_POP, 32'h0, 5'd0);
    add_op(KIND_READ, 32'h0, 5'd2);
    wait_drain();

    write_capacity(5'd0);
    add_op(KIND_PUSH, 32'h0000_0011, 5'd0);
    add_op(KIND_PUSH, 32'h0000_0022, 5'd0);
    add_op(KIND_READ, 32'h0, 5'd3);
    add_op(KIND_POP, 32'h0, 5'd0);
    add_op(KIND_POP, 32'h0, 5'd0);
    add_op(KIND_POP, 32'h0, 5'd0);
    add_op(KIND_PUSH, 32'h0000_0033, 5'd0);
    add_op(KIND_PUSH, 32'h0000_0044, 5'd0);
    add_op(KIND_POP, 32'h0, 5'd0);
    add_op(KIND_POP, 32'h0, 5'd0);
    add_op(KIND_POP, 32'h0, 5'd0);
    wait_drain();

    for (int p = 0; p < 7; p++) begin
      write_capacity(cap_plan[p]);
      if (p == 0) hold_req = 1'b1;
      if (p == 6) no_idle = 1'b1;
      add_random_ops(RANDOM_OPS);
      wait_drain();
    end

    repeat (40) @(posedge clk);
    if (expected_replies.size() != 0) begin
      $display("tb_top: %0d expected replies never arrived", expected_replies.size());
      n_errors++;
    end
    $display("tb_top: %0d operations (%0d push, %0d pop, %0d read, %0d unused kind)",
             n_kind[0] + n_kind[1] + n_kind[2] + n_kind[3], n_kind[0], n_kind[1],
             n_kind[2], n_kind[3]);
    $display("tb_top: %0d capacity writes, %0d pushes rejected, %0d empty pops, %0d %s",
             n_cap_writes, n_rejected, n_empty_pops, n_out_of_range,
             "reads out of range");
    $display("tb_top: %0d replies with the queue full, peak fill %0d",
             n_full_replies, peak_fill);
    if (n_errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
